// ===== rtl/core/rcs_pkg.sv =====
// rcs_pkg: shared types and constants for the relay candidate selector.
// No dependencies; every rtl/core file but rcs_fifo refers to it by scoped names.
package rcs_pkg;

   // Command codes on the request channel
   typedef enum logic [1:0] {
      CMD_OPEN  = 2'd0,
      CMD_INFO  = 2'd1,
      CMD_CLOSE = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   // Configuration register indexes
   localparam logic [1:0] CSR_OWN_POS_X  = 2'd0;
   localparam logic [1:0] CSR_OWN_POS_Y  = 2'd1;
   localparam logic [1:0] CSR_OWN_DIST   = 2'd2;

   // Classified operation handed from front to back
   typedef enum logic [3:0] {
      KIND_OPEN  = 4'b0001,
      KIND_INFO  = 4'b0010,
      KIND_CLOSE = 4'b0100,
      KIND_NOP   = 4'b1000
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] addr;
      logic        is_base;
      logic [15:0] energy;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [15:0] dcb;
   } item_type;

   typedef struct packed {
      logic [15:0] relay_addr;
      logic [15:0] base_addr;
      logic [15:0] dest_addr;
      logic        dest_valid;
      logic        took;
   } result_type;

   // Arithmetic unit operations
   typedef enum logic {
      SOP_SQRT  = 1'b0,
      SOP_SCORE = 1'b1
   } sop_type;

   typedef struct packed {
      logic        start;
      sop_type     op;
      logic [15:0] ax;
      logic [15:0] ay;
      logic [15:0] bx;
      logic [15:0] by;
      logic [15:0] energy;
      logic [16:0] dnode;
      logic [15:0] dbase;
      logic [15:0] dcand;
   } score_req_type;

   typedef struct packed {
      logic               done;
      logic [16:0]        root;
      logic signed [23:0] score;
   } score_rsp_type;

   localparam logic signed [23:0] SCORE_MIN = 24'sh800000;
   localparam logic signed [23:0] SCORE_MAX = 24'sh7FFFFF;

endpackage

// ===== rtl/core/relay_candidate_selector.sv =====
// relay_candidate_selector: top level; configuration registers and wiring.
// Depends on rcs_pkg, rcs_front, rcs_score, rcs_back and rcs_fifo.
//
//   channel  handshake          payload
//   req      req_push/req_full  command, cand_* fields
//   rsp      rsp_empty/rsp_pop  relay_addr, base_addr, dest_addr, dest_valid, took
//   csr      csr_valid/ready    csr_index, csr_wdata
//
// Open, close, no-op and ignored relay-info words are handled in the back end's idle state.
// A relay-info word taken as the first relay needs only the 17-step square root.
// A scored relay-info word needs the square root and two scores, each of two
// 49-step divisions and a 48-step shift-add product unless a divisor is zero.
// Two-entry queues sit before and after the back end; reset is synchronous.
module relay_candidate_selector (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_command,
   input  logic [15:0] req_cand_addr,
   input  logic        req_cand_is_base,
   input  logic [15:0] req_cand_energy,
   input  logic [15:0] req_cand_pos_x,
   input  logic [15:0] req_cand_pos_y,
   input  logic [15:0] req_cand_dist_to_base,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [15:0] rsp_relay_addr,
   output logic [15:0] rsp_base_addr,
   output logic [15:0] rsp_dest_addr,
   output logic        rsp_dest_valid,
   output logic        rsp_took_candidate,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic [15:0]            own_x_ff, own_y_ff, own_dist_ff;
   rcs_pkg::item_type      item;
   logic                   item_empty, item_pop;
   rcs_pkg::score_req_type sreq;
   rcs_pkg::score_rsp_type srsp;
   rcs_pkg::result_type    res, res_out;
   logic                   res_push, res_full;
   logic [$bits(rcs_pkg::result_type)-1:0] res_rdata;

   assign csr_ready = 1'b1;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         own_x_ff    <= 16'd0;
         own_y_ff    <= 16'd0;
         own_dist_ff <= 16'd0;
      end else if (csr_valid) begin
         unique case (csr_index)
            rcs_pkg::CSR_OWN_POS_X: own_x_ff    <= csr_wdata;
            rcs_pkg::CSR_OWN_POS_Y: own_y_ff    <= csr_wdata;
            rcs_pkg::CSR_OWN_DIST:  own_dist_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   rcs_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .command           (req_command),
      .cand_addr         (req_cand_addr),
      .cand_is_base      (req_cand_is_base),
      .cand_energy       (req_cand_energy),
      .cand_pos_x        (req_cand_pos_x),
      .cand_pos_y        (req_cand_pos_y),
      .cand_dist_to_base (req_cand_dist_to_base),
      .item_pop          (item_pop),
      .item              (item),
      .item_empty        (item_empty)
   );

   rcs_score u_score (
      .clock (clock),
      .reset (reset),
      .sreq  (sreq),
      .srsp  (srsp)
   );

   rcs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .item_empty (item_empty),
      .item_pop   (item_pop),
      .own_pos_x  (own_x_ff),
      .own_pos_y  (own_y_ff),
      .own_dist   (own_dist_ff),
      .sreq       (sreq),
      .srsp       (srsp),
      .res_full   (res_full),
      .res_push   (res_push),
      .res        (res)
   );

   rcs_fifo #(
      .Width ($bits(rcs_pkg::result_type))
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .wdata (res),
      .full  (res_full),
      .pop   (rsp_pop),
      .rdata (res_rdata),
      .empty (rsp_empty)
   );

   assign res_out            = rcs_pkg::result_type'(res_rdata);
   assign rsp_relay_addr     = res_out.relay_addr;
   assign rsp_base_addr      = res_out.base_addr;
   assign rsp_dest_addr      = res_out.dest_addr;
   assign rsp_dest_valid     = res_out.dest_valid;
   assign rsp_took_candidate = res_out.took;

endmodule

// ===== rtl/core/rcs_fifo.sv =====
// rcs_fifo: two-entry queue of Width-bit words.
// No dependencies.
module rcs_fifo #(
   parameter int Width = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [Width-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [Width-1:0] rdata,
   output logic             empty
);

   logic [Width-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign rdata   = mem_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the word
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ===== rtl/core/rcs_front.sv =====
// rcs_front: accepts request words, classifies the command, queues the item.
// Depends on rcs_pkg and rcs_fifo.
module rcs_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [1:0]         command,
   input  logic [15:0]        cand_addr,
   input  logic               cand_is_base,
   input  logic [15:0]        cand_energy,
   input  logic [15:0]        cand_pos_x,
   input  logic [15:0]        cand_pos_y,
   input  logic [15:0]        cand_dist_to_base,
   input  logic               item_pop,
   output rcs_pkg::item_type  item,
   output logic               item_empty
);

   rcs_pkg::item_type item_w;
   logic [$bits(rcs_pkg::item_type)-1:0] rdata;

   // Classify the command
   always_comb begin
      item_w.addr    = cand_addr;
      item_w.is_base = cand_is_base;
      item_w.energy  = cand_energy;
      item_w.pos_x   = cand_pos_x;
      item_w.pos_y   = cand_pos_y;
      item_w.dcb     = cand_dist_to_base;
      unique case (rcs_pkg::cmd_type'(command))
         rcs_pkg::CMD_OPEN:  item_w.kind = rcs_pkg::KIND_OPEN;
         rcs_pkg::CMD_INFO:  item_w.kind = rcs_pkg::KIND_INFO;
         rcs_pkg::CMD_CLOSE: item_w.kind = rcs_pkg::KIND_CLOSE;
         default:            item_w.kind = rcs_pkg::KIND_NOP;
      endcase
   end

   rcs_fifo #(
      .Width ($bits(rcs_pkg::item_type))
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (item_w),
      .full  (req_full),
      .pop   (item_pop),
      .rdata (rdata),
      .empty (item_empty)
   );

   assign item = rcs_pkg::item_type'(rdata);

endmodule

// ===== rtl/core/rcs_score.sv =====
// rcs_score: iterative arithmetic unit: distance square root and relay score.
// Shares one 17x17 multiplier and one restoring divider; depends on rcs_pkg.
module rcs_score (
   input  logic                    clock,
   input  logic                    reset,
   input  rcs_pkg::score_req_type  sreq,
   output rcs_pkg::score_rsp_type  srsp
);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_MUL   = 7'b0000010,
      S_PREP  = 7'b0000100,
      S_SQRT  = 7'b0001000,
      S_DIV_R = 7'b0010000,
      S_DIV_C = 7'b0100000,
      S_PROD  = 7'b1000000
   } state_type;

   state_type              state_ff, state_in;
   rcs_pkg::score_req_type opd_ff, opd_in;
   logic [2:0]             step_ff, step_in;
   logic [5:0]             cnt_ff, cnt_in;
   logic [33:0]            prod_ff [5];
   logic [16:0]            mul_a, mul_b;
   logic [33:0]            mul_p;
   logic [15:0]            abs_dx, abs_dy;
   logic                   mul_last;
   logic [33:0]            sq_src_ff, sq_src_in;
   logic [18:0]            sq_rem_ff, sq_rem_in;
   logic [16:0]            root_ff, root_in;
   logic [20:0]            sq_t, sq_trial, sq_diff;
   logic                   sq_ge;
   logic [32:0]            rem_ff, rem_in;
   logic [48:0]            dq_ff, dq_in;
   logic [32:0]            div_ff, div_in;
   logic [33:0]            div_t, div_r;
   logic                   div_ge;
   logic [48:0]            div_q;
   logic [35:0]            num_ff, num_in;
   logic [35:0]            mag36;
   logic                   neg_ff, neg_in;
   logic [41:0]            r_ff, r_in;
   logic [47:0]            cm_ff, cm_in;
   logic [36:0]            acc_ff, acc_in;
   logic                   sat_ff, sat_in;
   logic [42:0]            pp;
   logic [23:0]            pmag;
   logic signed [23:0]     score_ff, score_in;
   logic                   done_ff, done_in;

   // Shared multiplier operand select
   always_comb begin
      abs_dx = (opd_ff.ax >= opd_ff.bx) ? opd_ff.ax - opd_ff.bx : opd_ff.bx - opd_ff.ax;
      abs_dy = (opd_ff.ay >= opd_ff.by) ? opd_ff.ay - opd_ff.by : opd_ff.by - opd_ff.ay;
      if (opd_ff.op == rcs_pkg::SOP_SQRT) begin
         mul_last = (step_ff == 3'd1);
         if (step_ff == 3'd0) begin
            mul_a = {1'b0, abs_dx};
            mul_b = {1'b0, abs_dx};
         end else begin
            mul_a = {1'b0, abs_dy};
            mul_b = {1'b0, abs_dy};
         end
      end else begin
         mul_last = (step_ff == 3'd4);
         unique case (step_ff)
            3'd0: begin
               mul_a = {1'b0, opd_ff.energy};
               mul_b = opd_ff.dnode;
            end
            3'd1: begin
               mul_a = opd_ff.dnode;
               mul_b = opd_ff.dnode;
            end
            3'd2: begin
               mul_a = {1'b0, opd_ff.dbase};
               mul_b = {1'b0, opd_ff.dbase};
            end
            3'd3: begin
               mul_a = {1'b0, opd_ff.dcand};
               mul_b = {1'b0, opd_ff.dcand};
            end
            default: begin
               mul_a = {1'b0, opd_ff.dcand};
               mul_b = {1'b0, opd_ff.dbase};
            end
         endcase
      end
      mul_p = mul_a * mul_b;
   end

   // Square root digit step: two radicand bits per cycle
   always_comb begin
      sq_t     = {sq_rem_ff, sq_src_ff[33:32]};
      sq_trial = {2'b00, root_ff, 2'b01};
      sq_ge    = (sq_t >= sq_trial);
      sq_diff  = sq_t - sq_trial;
      sq_rem_in = sq_ge ? sq_diff[18:0] : sq_t[18:0];
      root_in   = {root_ff[15:0], sq_ge};
   end

   // Restoring divider step: one quotient bit per cycle
   always_comb begin
      div_t  = {rem_ff, dq_ff[48]};
      div_ge = (div_t >= {1'b0, div_ff});
      div_r  = div_ge ? div_t - {1'b0, div_ff} : div_t;
      div_q  = {dq_ff[47:0], div_ge};
   end

   // Shift-add product step with sticky saturation
   always_comb begin
      pp   = {5'd0, acc_ff, 1'b0} + (cm_ff[47] ? {1'b0, r_ff} : 43'd0);
      pmag = {1'b0, pp[36:14]};
   end

   assign mag36 = num_ff[35] ? (36'd0 - num_ff) : num_ff;

   // Sequence the operation
   always_comb begin
      state_in  = state_ff;
      opd_in    = opd_ff;
      step_in   = step_ff;
      cnt_in    = cnt_ff;
      sq_src_in = sq_src_ff;
      rem_in    = rem_ff;
      dq_in     = dq_ff;
      div_in    = div_ff;
      num_in    = num_ff;
      neg_in    = neg_ff;
      r_in      = r_ff;
      cm_in     = cm_ff;
      acc_in    = acc_ff;
      sat_in    = sat_ff;
      score_in  = score_ff;
      done_in   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (sreq.start) begin
               opd_in   = sreq;
               step_in  = 3'd0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            step_in = step_ff + 3'd1;
            if (mul_last) begin
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            cnt_in = 6'd0;
            if (opd_ff.op == rcs_pkg::SOP_SQRT) begin
               sq_src_in = prod_ff[0] + prod_ff[1];
               state_in  = S_SQRT;
            end else if (opd_ff.dcand == 16'd0 || opd_ff.dbase == 16'd0) begin
               score_in = rcs_pkg::SCORE_MIN;
               done_in  = 1'b1;
               state_in = S_IDLE;
            end else begin
               rem_in   = 33'd0;
               dq_in    = {8'd0, prod_ff[0][32:0], 8'd0};
               div_in   = {17'd0, opd_ff.dcand};
               num_in   = {2'b00, prod_ff[1]} + {4'd0, prod_ff[2][31:0]}
                          - {4'd0, prod_ff[3][31:0]};
               state_in = S_DIV_R;
            end
         end
         S_SQRT: begin
            sq_src_in = {sq_src_ff[31:0], 2'b00};
            cnt_in    = cnt_ff + 6'd1;
            if (cnt_ff == 6'd16) begin
               done_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_DIV_R: begin
            rem_in = div_r[32:0];
            dq_in  = div_q;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd48) begin
               r_in     = div_q[41:0];
               neg_in   = num_ff[35];
               rem_in   = 33'd0;
               dq_in    = {1'b0, mag36[33:0], 14'd0};
               div_in   = {prod_ff[4][31:0], 1'b0};
               cnt_in   = 6'd0;
               state_in = S_DIV_C;
            end
         end
         S_DIV_C: begin
            rem_in = div_r[32:0];
            dq_in  = div_q;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd48) begin
               cm_in    = div_q[47:0];
               acc_in   = 37'd0;
               sat_in   = 1'b0;
               cnt_in   = 6'd0;
               state_in = S_PROD;
            end
         end
         S_PROD: begin
            acc_in = pp[36:0];
            sat_in = sat_ff | (pp[42:37] != 6'd0);
            cm_in  = {cm_ff[46:0], 1'b0};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd47) begin
               if (sat_in) begin
                  score_in = neg_ff ? rcs_pkg::SCORE_MIN : rcs_pkg::SCORE_MAX;
               end else begin
                  score_in = neg_ff ? $signed(24'd0 - pmag) : $signed(pmag);
               end
               done_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // Hold datapath registers
   always_ff @(posedge clock) begin
      opd_ff    <= opd_in;
      step_ff   <= step_in;
      cnt_ff    <= cnt_in;
      sq_src_ff <= sq_src_in;
      rem_ff    <= rem_in;
      dq_ff     <= dq_in;
      div_ff    <= div_in;
      num_ff    <= num_in;
      neg_ff    <= neg_in;
      r_ff      <= r_in;
      cm_ff     <= cm_in;
      acc_ff    <= acc_in;
      sat_ff    <= sat_in;
      score_ff  <= score_in;
      if (state_ff == S_MUL) begin
         prod_ff[step_ff] <= mul_p;
      end
      if (state_ff == S_PREP) begin
         sq_rem_ff <= 19'd0;
         root_ff   <= 17'd0;
      end else if (state_ff == S_SQRT) begin
         sq_rem_ff <= sq_rem_in;
         root_ff   <= root_in;
      end
   end

   assign srsp.done  = done_ff;
   assign srsp.root  = root_ff;
   assign srsp.score = score_ff;

endmodule

// ===== rtl/core/rcs_back.sv =====
// rcs_back: window, base and relay state; carries out queued items.
// Depends on rcs_pkg and rcs_score (through the srsp/sreq structs).
module rcs_back (
   input  logic                    clock,
   input  logic                    reset,
   input  rcs_pkg::item_type       item,
   input  logic                    item_empty,
   output logic                    item_pop,
   input  logic [15:0]             own_pos_x,
   input  logic [15:0]             own_pos_y,
   input  logic [15:0]             own_dist,
   output rcs_pkg::score_req_type  sreq,
   input  rcs_pkg::score_rsp_type  srsp,
   input  logic                    res_full,
   output logic                    res_push,
   output rcs_pkg::result_type     res
);

   typedef enum logic [3:0] {
      B_IDLE = 4'b0001,
      B_SQRT = 4'b0010,
      B_CUR  = 4'b0100,
      B_CAND = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   rcs_pkg::item_type  item_ff, item_in;
   logic               window_ff, window_in;
   logic [15:0]        base_ff, base_in;
   logic [15:0]        relay_ff, relay_in;
   logic [15:0]        renergy_ff, renergy_in;
   logic [15:0]        rdist_ff, rdist_in;
   logic [16:0]        rd_ff, rd_in;
   logic [16:0]        d_ff, d_in;
   logic signed [23:0] cur_ff, cur_in;
   logic               take;
   logic [16:0]        take_d;

   always_comb begin
      state_in   = state_ff;
      item_in    = item_ff;
      window_in  = window_ff;
      base_in    = base_ff;
      relay_in   = relay_ff;
      renergy_in = renergy_ff;
      rdist_in   = rdist_ff;
      rd_in      = rd_ff;
      d_in       = d_ff;
      cur_in     = cur_ff;
      item_pop   = 1'b0;
      res_push   = 1'b0;
      res        = '0;
      take       = 1'b0;
      take_d     = d_ff;
      sreq       = '0;
      sreq.op     = rcs_pkg::SOP_SCORE;
      sreq.ax     = own_pos_x;
      sreq.ay     = own_pos_y;
      sreq.bx     = item.pos_x;
      sreq.by     = item.pos_y;
      sreq.dbase  = own_dist;
      sreq.energy = item_ff.energy;
      sreq.dnode  = d_ff;
      sreq.dcand  = item_ff.dcb;
      unique case (state_ff)
         B_IDLE: begin
            if (!item_empty && !res_full) begin
               item_pop = 1'b1;
               item_in  = item;
               unique case (item.kind)
                  rcs_pkg::KIND_OPEN: begin
                     relay_in  = 16'd0;
                     window_in = 1'b1;
                     res_push  = 1'b1;
                  end
                  rcs_pkg::KIND_CLOSE: begin
                     // Report base first, then relay
                     if (base_ff != 16'd0) begin
                        res.dest_addr  = base_ff;
                        res.dest_valid = 1'b1;
                     end else if (relay_ff != 16'd0) begin
                        res.dest_addr  = relay_ff;
                        res.dest_valid = 1'b1;
                     end
                     window_in = 1'b0;
                     relay_in  = 16'd0;
                     res_push  = 1'b1;
                  end
                  rcs_pkg::KIND_INFO: begin
                     priority if (!window_ff) begin
                        res_push = 1'b1;
                     end else if (item.is_base) begin
                        base_in  = item.addr;
                        res.took = 1'b1;
                        res_push = 1'b1;
                     end else if (base_ff != 16'd0) begin
                        res_push = 1'b1;
                     end else begin
                        sreq.start = 1'b1;
                        sreq.op    = rcs_pkg::SOP_SQRT;
                        state_in   = B_SQRT;
                     end
                  end
                  default: begin
                     res_push = 1'b1;
                  end
               endcase
            end
         end
         B_SQRT: begin
            if (srsp.done) begin
               d_in = srsp.root;
               if (relay_ff == 16'd0) begin
                  take     = 1'b1;
                  take_d   = srsp.root;
                  state_in = B_IDLE;
               end else begin
                  // Score the current relay first
                  sreq.start  = 1'b1;
                  sreq.energy = renergy_ff;
                  sreq.dnode  = rd_ff;
                  sreq.dcand  = rdist_ff;
                  state_in    = B_CUR;
               end
            end
         end
         B_CUR: begin
            if (srsp.done) begin
               cur_in     = srsp.score;
               sreq.start = 1'b1;
               state_in   = B_CAND;
            end
         end
         B_CAND: begin
            if (srsp.done) begin
               take     = (srsp.score > cur_ff);
               res_push = ~take;
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase

      // Store the candidate as relay
      if (take) begin
         relay_in   = item_ff.addr;
         renergy_in = item_ff.energy;
         rdist_in   = item_ff.dcb;
         rd_in      = take_d;
         res.took   = 1'b1;
         res_push   = 1'b1;
      end
      res.relay_addr = relay_in;
      res.base_addr  = base_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= B_IDLE;
         window_ff  <= 1'b0;
         base_ff    <= 16'd0;
         relay_ff   <= 16'd0;
         renergy_ff <= 16'd0;
         rdist_ff   <= 16'd0;
         rd_ff      <= 17'd0;
      end else begin
         state_ff   <= state_in;
         window_ff  <= window_in;
         base_ff    <= base_in;
         relay_ff   <= relay_in;
         renergy_ff <= renergy_in;
         rdist_ff   <= rdist_in;
         rd_ff      <= rd_in;
      end
   end

   // Hold the item in work and intermediate results
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      d_ff    <= d_in;
      cur_ff  <= cur_in;
   end

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking testbench for relay_candidate_selector.
// Depends on rcs_pkg and the RTL under rtl/core; a scoreboard class predicts each word.
`timescale 1ns / 1ps

class relay_scoreboard;
   logic [15:0] own_x, own_y, own_dist;
   bit          window_open;
   logic [15:0] base_address, relay_address, relay_energy, relay_dist;
   logic [16:0] relay_distance;
   rcs_pkg::result_type pending[$];
   int errors;

   function new();
      own_x = 0; own_y = 0; own_dist = 0;
      window_open = 0; base_address = 0; relay_address = 0;
      relay_energy = 0; relay_dist = 0; relay_distance = 0;
      errors = 0;
   endfunction

   function void write_reg(logic [1:0] idx, logic [15:0] v);
      case (idx)
         rcs_pkg::CSR_OWN_POS_X: own_x = v;
         rcs_pkg::CSR_OWN_POS_Y: own_y = v;
         rcs_pkg::CSR_OWN_DIST:  own_dist = v;
         default: ;
      endcase
   endfunction

   function longint unsigned isqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // Score energy*d/dcb*cos(angle) in Q16.8, saturating
   function int relay_merit(longint unsigned energy, longint unsigned d,
                            longint unsigned dbase, longint unsigned dcand);
      longint unsigned r, cmag, prod;
      longint num, den;
      bit neg;
      if (dcand == 0 || dbase == 0) return -8388608;
      r = (energy * d * 256) / dcand;
      num = longint'(d * d) + longint'(dbase * dbase) - longint'(dcand * dcand);
      den = 2 * longint'(dcand) * longint'(dbase);
      neg = num < 0;
      cmag = neg ? longint'(-num) : longint'(num);
      cmag = (cmag * 16384) / longint'(den);
      if (r == 0 || cmag == 0) return 0;
      if (cmag > 64'hFFFF_FFFF_FFFF_FFFF / r) return neg ? -8388608 : 8388607;
      prod = (r * cmag) >> 14;
      if (neg) return (prod >= 8388608) ? -8388608 : -int'(prod);
      return (prod > 8388607) ? 8388607 : int'(prod);
   endfunction

   function void note_request(rcs_pkg::cmd_type cmd, logic [15:0] addr, logic is_base,
                              logic [15:0] energy, logic [15:0] cx, logic [15:0] cy,
                              logic [15:0] cdist);
      rcs_pkg::result_type res;
      longint dx, dy;
      longint unsigned d;
      bit take;
      res = '0;
      case (cmd)
         rcs_pkg::CMD_OPEN: begin
            relay_address = 0;
            window_open = 1;
         end
         rcs_pkg::CMD_INFO: begin
            if (window_open) begin
               if (is_base) begin
                  base_address = addr;
                  res.took = 1;
               end else if (base_address == 0) begin
                  dx = longint'(own_x) - longint'(cx);
                  dy = longint'(own_y) - longint'(cy);
                  d = isqrt(longint'(dx * dx) + longint'(dy * dy));
                  take = (relay_address == 0);
                  if (!take)
                     take = relay_merit(energy, d, own_dist, cdist) >
                            relay_merit(relay_energy, relay_distance, own_dist, relay_dist);
                  if (take) begin
                     relay_address = addr;
                     relay_energy = energy;
                     relay_dist = cdist;
                     relay_distance = d[16:0];
                     res.took = 1;
                  end
               end
            end
         end
         rcs_pkg::CMD_CLOSE: begin
            if (base_address != 0) begin
               res.dest_addr = base_address;
               res.dest_valid = 1;
            end else if (relay_address != 0) begin
               res.dest_addr = relay_address;
               res.dest_valid = 1;
            end
            window_open = 0;
            relay_address = 0;
         end
         default: ;
      endcase
      res.relay_addr = relay_address;
      res.base_addr = base_address;
      pending.push_back(res);
   endfunction

   function void check_result(rcs_pkg::result_type got);
      rcs_pkg::result_type exp;
      if (pending.size() == 0) begin
         $display("%0t: unexpected result word %h", $time, got);
         errors++;
         return;
      end
      exp = pending.pop_front();
      if (got.relay_addr !== exp.relay_addr) begin
         $display("%0t: relay_addr exp %h got %h", $time, exp.relay_addr, got.relay_addr);
         errors++;
      end
      if (got.base_addr !== exp.base_addr) begin
         $display("%0t: base_addr exp %h got %h", $time, exp.base_addr, got.base_addr);
         errors++;
      end
      if (got.dest_addr !== exp.dest_addr) begin
         $display("%0t: dest_addr exp %h got %h", $time, exp.dest_addr, got.dest_addr);
         errors++;
      end
      if (got.dest_valid !== exp.dest_valid) begin
         $display("%0t: dest_valid exp %b got %b", $time, exp.dest_valid, got.dest_valid);
         errors++;
      end
      if (got.took !== exp.took) begin
         $display("%0t: took_candidate exp %b got %b", $time, exp.took, got.took);
         errors++;
      end
   endfunction
endclass

module tb_top;
   import rcs_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_push = 0;
   logic        req_full;
   logic [1:0]  req_command = 0;
   logic [15:0] req_cand_addr = 0;
   logic        req_cand_is_base = 0;
   logic [15:0] req_cand_energy = 0;
   logic [15:0] req_cand_pos_x = 0;
   logic [15:0] req_cand_pos_y = 0;
   logic [15:0] req_cand_dist_to_base = 0;
   logic        rsp_empty;
   logic        rsp_pop = 0;
   logic [15:0] rsp_relay_addr, rsp_base_addr, rsp_dest_addr;
   logic        rsp_dest_valid, rsp_took_candidate;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [1:0]  csr_index = 0;
   logic [15:0] csr_wdata = 0;

   relay_scoreboard relay_sb;
   bit              draining = 0;

   relay_candidate_selector dut (.*);

   always #6 clock = ~clock;

   // Gap length: mostly short, a few long
   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 40) return 0;
      if (p < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 400);
   endfunction

   // Pop side: random stalls, check each word taken
   initial begin : pop_side
      int g;
      @(posedge clock iff !reset);
      forever begin
         g = draining ? 0 : pick_gap();
         if (g != 0) begin
            rsp_pop <= 0;
            repeat (g) @(posedge clock);
         end
         rsp_pop <= 1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
         relay_sb.check_result('{rsp_relay_addr, rsp_base_addr, rsp_dest_addr,
                                 rsp_dest_valid, rsp_took_candidate});
      end
   end

   task automatic send_word(cmd_type cmd, logic [15:0] addr, logic is_base,
                            logic [15:0] energy, logic [15:0] x, logic [15:0] y,
                            logic [15:0] dcb);
      int g;
      req_push <= 1;
      req_command <= cmd;
      req_cand_addr <= addr;
      req_cand_is_base <= is_base;
      req_cand_energy <= energy;
      req_cand_pos_x <= x;
      req_cand_pos_y <= y;
      req_cand_dist_to_base <= dcb;
      @(posedge clock);
      while (req_full) @(posedge clock);
      relay_sb.note_request(cmd, addr, is_base, energy, x, y, dcb);
      g = pick_gap();
      if (g != 0) begin
         req_push <= 0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic write_csr(logic [1:0] idx, logic [15:0] v);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      relay_sb.write_reg(idx, v);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   // Hold until every expected word is back, then let the back end settle
   task automatic drain();
      req_push <= 0;
      draining = 1;
      while (relay_sb.pending.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      draining = 0;
   endtask

   task automatic set_position(logic [15:0] x, logic [15:0] y, logic [15:0] d);
      drain();
      write_csr(CSR_OWN_POS_X, x);
      write_csr(CSR_OWN_POS_Y, y);
      write_csr(CSR_OWN_DIST, d);
   endtask

   function automatic logic [15:0] rnd16();
      int p;
      p = $urandom_range(0, 9);
      if (p == 0) return 16'h0000;
      if (p == 1) return 16'hFFFF;
      if (p < 6) return 16'($urandom_range(0, 4095));
      return 16'($urandom);
   endfunction

   // Random relay-info word, mostly non-base
   task automatic send_info(bit base_ok);
      send_word(CMD_INFO, ($urandom_range(0, 30) == 0) ? 16'h0 : 16'($urandom),
                base_ok && ($urandom_range(0, 40) == 0), rnd16(), rnd16(), rnd16(), rnd16());
   endtask

   initial begin : stimulus
      int n, k;
      relay_sb = new();
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: info with window closed, zero divisors, ties, extremes
      send_word(CMD_INFO, 16'h1111, 0, 16'h10, 16'h10, 16'h10, 16'h10);
      send_word(CMD_CLOSE, 0, 0, 0, 0, 0, 0);
      send_word(CMD_NOP, 16'hFFFF, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_word(CMD_OPEN, 0, 0, 0, 0, 0, 0);
      send_word(CMD_INFO, 16'h0000, 0, 16'h5, 16'h20, 16'h20, 16'h40);
      send_word(CMD_INFO, 16'h0101, 0, 16'h5, 16'h20, 16'h20, 16'h40);
      send_word(CMD_CLOSE, 0, 0, 0, 0, 0, 0);
      set_position(16'h0100, 16'h0200, 16'h0800);
      send_word(CMD_OPEN, 0, 0, 0, 0, 0, 0);
      send_word(CMD_OPEN, 0, 0, 0, 0, 0, 0);
      send_word(CMD_INFO, 16'h0202, 0, 16'h100, 16'h0300, 16'h0300, 16'h0600);
      send_word(CMD_INFO, 16'h0303, 0, 16'h100, 16'h0300, 16'h0300, 16'h0600);
      send_word(CMD_INFO, 16'h0404, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
      send_word(CMD_INFO, 16'h0505, 0, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
      send_word(CMD_INFO, 16'h0606, 0, 16'hFFFF, 16'h0100, 16'h0200, 16'h0001);
      send_word(CMD_CLOSE, 0, 0, 0, 0, 0, 0);
      set_position(16'hFFFF, 16'hFFFF, 16'h0000);
      send_word(CMD_OPEN, 0, 0, 0, 0, 0, 0);
      send_word(CMD_INFO, 16'h0707, 0, 16'h1, 16'h0, 16'h0, 16'h10);
      send_word(CMD_INFO, 16'h0808, 0, 16'h9, 16'h0, 16'h0, 16'h10);
      send_word(CMD_CLOSE, 0, 0, 0, 0, 0, 0);

      // Random phases; base is never cleared, so it is announced only late
      for (n = 0; n < 12; n++) begin
         set_position(rnd16(), rnd16(), (n == 3) ? 16'h0000 : rnd16());
         k = 0;
         while (k < 110) begin
            send_word(CMD_OPEN, 0, 0, 0, 0, 0, 0);
            repeat ($urandom_range(1, 8)) begin
               if ($urandom_range(0, 12) == 0)
                  send_word(cmd_type'($urandom_range(0, 3)), 16'($urandom),
                            (n >= 10) && 1'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom));
               else
                  send_info(n >= 10);
               k++;
            end
            send_word(CMD_CLOSE, 16'($urandom), 1'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom), 16'($urandom));
            k += 2;
            if ($urandom_range(0, 6) == 0) begin
               send_info(0);
               k++;
            end
         end
      end

      // Directed: base announcement, then info ignored while a base is known
      send_word(CMD_OPEN, 0, 0, 0, 0, 0, 0);
      send_word(CMD_INFO, 16'hBA5E, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_word(CMD_INFO, 16'h0909, 0, 16'h9, 16'h0, 16'h0, 16'h10);
      send_word(CMD_CLOSE, 0, 0, 0, 0, 0, 0);
      send_word(CMD_CLOSE, 0, 0, 0, 0, 0, 0);

      drain();
      if (relay_sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin : watchdog
      #600ms;
      $display("DONE: errors detected");
      $finish;
   end
endmodule
